@@ rtl/deadline_timer_queue_core_defines.svh @@
// ---------------------------------------------------------------------------
// deadline_timer_queue_core_defines
// Assertion macros used by the timer queue core.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// checked only outside reset
`define DTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dtq_pkg.sv @@
// ---------------------------------------------------------------------------
// dtq_pkg
// Transaction types and codes of the deadline timer queue.
// ---------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int DEPTH     = 64;
  localparam int TIME_BITS = 48;

  localparam int FUNC_W  = 2;
  localparam int DELAY_W = 32;
  localparam int NOW_W   = 48;
  localparam int ID_W    = 32;
  localparam int STAT_W  = 2;
  localparam int EARL_W  = 48;
  localparam int PCNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_START = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FIRE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_REPEAT = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DELAY_W-1:0] delay_ms;
    logic [NOW_W-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   timer_id;
    logic              last;
    logic [STAT_W-1:0] status;
    logic              earliest_valid;
    logic [EARL_W-1:0] earliest_deadline;
    logic [PCNT_W-1:0] pending_count;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/dtq_ram.sv @@
// ---------------------------------------------------------------------------
// dtq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/deadline_timer_queue_core.sv @@
// ---------------------------------------------------------------------------
// deadline_timer_queue_core
// Deadline-ordered timer queue held in a circular buffer in one RAM.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_t  (func, delay_ms, now_ms)
//  out     | output    | out_valid/out_stall| out_t (one or more per item)
//
//  Add moves later entries up a place, then writes the new one (if full,
//  status FULL only); start adds now to each pending deadline; fire scans
//  from the head to the first unexpired entry, then emits each expired one.
//  Spare code: bare response. RAM: one entry read and one written per cycle.
//  Reset clears control state only; the RAM has no clearing pass.
//  in_stall is high while an item is in work; a stalled result holds it off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "deadline_timer_queue_core_defines.svh"

module deadline_timer_queue_core
  import dtq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TIME_BITS + ID_W;
  localparam logic [63:0] TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ADD_CMP = 8'b0000_0010,
    S_ADD_WR  = 8'b0000_0100,
    S_ST_LOOP = 8'b0000_1000,
    S_FI_LOOP = 8'b0001_0000,
    S_EM_RD   = 8'b0010_0000,
    S_EM_OUT  = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] clamp_t(input logic [63:0] v);
    return (v > TMAX64) ? TMAX64[TIME_BITS-1:0] : v[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = (TIME_BITS+1)'(a) + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic                 started_r, started_nxt;
  logic [TIME_BITS-1:0] earliest_r, earliest_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        nf_r, nf_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [STAT_W-1:0]    st_r, st_nxt;
  out_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;
  logic [TIME_BITS-1:0] now_c;
  logic [TIME_BITS-1:0] delay_c;
  logic [CW-1:0]        k_inc;
  logic [TIME_BITS-1:0] st_sum;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic [TIME_BITS-1:0] rd_dl;
  logic [ID_W-1:0]      rd_id;

  dtq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_dl    = rd_data[EW-1:ID_W];
  assign rd_id    = rd_data[ID_W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign now_c    = clamp_t(64'(in_data.now_ms));
  assign delay_c  = clamp_t(64'(in_data.delay_ms));
  assign k_inc    = k_r + CW'(1);
  assign st_sum   = sat_add(rd_dl, now_r);

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    head_nxt     = head_r;
    next_id_nxt  = next_id_r;
    started_nxt  = started_r;
    earliest_nxt = earliest_r;
    t_nxt        = t_r;
    now_nxt      = now_r;
    k_nxt        = k_r;
    nf_nxt       = nf_r;
    base_nxt     = base_r;
    id_nxt       = id_r;
    st_nxt       = st_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = {t_r, id_r};
    load_out     = 1'b0;
    out_nxt.fired             = 1'b0;
    out_nxt.timer_id          = id_r;
    out_nxt.last              = 1'b1;
    out_nxt.status            = st_r;
    out_nxt.earliest_valid    = (occ_r != '0);
    out_nxt.earliest_deadline = (occ_r != '0) ? EARL_W'(earliest_r) : '0;
    out_nxt.pending_count     = PCNT_W'(occ_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt   = now_c;
          id_nxt    = '0;
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
          unique case (in_data.func)
            FN_ADD: begin
              if (occ_r == CW'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                t_nxt       = started_r ? sat_add(now_c, delay_c) : delay_c;
                id_nxt      = next_id_r;
                next_id_nxt = next_id_r + ID_W'(1);
                if (occ_r == '0) begin
                  state_nxt = S_ADD_WR;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = phys(head_r, occ_r - CW'(1));
                  k_nxt     = occ_r - CW'(1);
                  state_nxt = S_ADD_CMP;
                end
              end
            end
            FN_START: begin
              if (started_r) begin
                st_nxt = ST_REPEAT;
              end else begin
                started_nxt = 1'b1;
                if (occ_r != '0) begin
                  rd_en     = 1'b1;
                  k_nxt     = '0;
                  state_nxt = S_ST_LOOP;
                end
              end
            end
            FN_FIRE: begin
              if (occ_r != '0) begin
                rd_en     = 1'b1;
                k_nxt     = '0;
                state_nxt = S_FI_LOOP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_ADD_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, k_inc);
        if (rd_dl > t_r) begin
          wr_data = rd_data;
          if (k_r == '0) begin
            state_nxt = S_ADD_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, k_r - CW'(1));
            k_nxt   = k_r - CW'(1);
          end
        end else begin
          occ_nxt   = occ_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_ADD_WR: begin
        wr_en        = 1'b1;
        earliest_nxt = t_r;
        occ_nxt      = occ_r + CW'(1);
        state_nxt    = S_RESP;
      end

      S_ST_LOOP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, k_r);
        wr_data = {st_sum, rd_id};
        if (k_r == '0) begin
          earliest_nxt = st_sum;
        end
        if (k_inc < occ_r) begin
          rd_en   = 1'b1;
          rd_addr = phys(head_r, k_inc);
          k_nxt   = k_inc;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_FI_LOOP: begin
        if (rd_dl <= now_r) begin
          if (k_inc < occ_r) begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, k_inc);
            k_nxt   = k_inc;
          end else begin
            nf_nxt    = occ_r;
            base_nxt  = head_r;
            head_nxt  = phys(head_r, occ_r);
            occ_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_EM_RD;
          end
        end else if (k_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          nf_nxt       = k_r;
          base_nxt     = head_r;
          head_nxt     = phys(head_r, k_r);
          occ_nxt      = occ_r - k_r;
          earliest_nxt = rd_dl;
          k_nxt        = '0;
          state_nxt    = S_EM_RD;
        end
      end

      S_EM_RD: begin
        if (out_free) begin
          rd_en     = 1'b1;
          rd_addr   = phys(base_r, k_r);
          state_nxt = S_EM_OUT;
        end
      end

      S_EM_OUT: begin
        load_out         = 1'b1;
        out_nxt.fired    = 1'b1;
        out_nxt.timer_id = rd_id;
        out_nxt.status   = ST_OK;
        out_nxt.last     = (k_inc == nf_r);
        if (k_inc == nf_r) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_EM_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      next_id_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      next_id_r   <= next_id_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    earliest_r <= earliest_nxt;
    t_r        <= t_nxt;
    now_r      <= now_nxt;
    k_r        <= k_nxt;
    nf_r       <= nf_nxt;
    base_r     <= base_nxt;
    id_r       <= id_nxt;
    st_r       <= st_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DTQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset left work")
  `DTQ_ASSERT(a_occ_bound, occ_r <= CW'(DEPTH), "occupancy above depth")
  `DTQ_ASSERT(a_accept_busy, in_acc |=> (state_r != S_IDLE), "accepted item left no work")
  `DTQ_ASSERT(a_idle_no_write, (state_r == S_IDLE) |-> !wr_en, "RAM write while idle")
  `DTQ_ASSERT(a_rw_apart, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write collide")

endmodule

`default_nettype wire
